// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of the slot table block.
// No dependencies; take in with `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define KST_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define KST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well.
`define KST_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/kst_pkg.sv
// Types and constants for the keyed slot table with timeout.
// No dependencies; imported by the top level and the checker.
package kst_pkg;

    localparam int NAME_LOW_W  = 64;
    localparam int NAME_HIGH_W = 56;
    localparam int NAME_MAX_W  = NAME_LOW_W + NAME_HIGH_W;
    localparam int TIME_W      = 32;
    localparam int OUT_IDX_W   = 2;
    localparam int STATUS_W    = 3;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd60000;

    typedef enum logic {
        OP_UPDATE  = 1'b0,
        OP_TIMEOUT = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_MATCHED = 3'd0,
        ST_CLAIMED = 3'd1,
        ST_FULL    = 3'd2,
        ST_EXPIRED = 3'd3,
        ST_NONE    = 3'd4
    } status_t;

endpackage

// File: hdl/kst_prio.sv
// Lowest-set-bit priority encoder over the slot vector.
// Depends on nothing but its parameter; used by the top level.
module kst_prio #(
    parameter int N     = 4,
    parameter int IDX_W = (N > 1) ? $clog2(N) : 1
) (
    input  logic [N-1:0]     req,
    output logic             found,
    output logic [IDX_W-1:0] idx
);

    logic [N-1:0] lowest;

    always_comb begin
        lowest = req & (~req + N'(1));
        idx    = '0;
        for (int i = 0; i < N; i++) begin
            if (lowest[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
        found = |req;
    end

endmodule

// File: hdl/keyed_slot_table_with_timeout_unit.sv
// Keyed slot table with timeout: top level.
// Depends on kst_pkg and kst_prio.
//
// Takes one word per cycle. An update word (opcode 0) looks its name up in
// every active slot at once: a hit refreshes the stamp, a miss claims the
// lowest free slot or reports the table full. A timeout word (opcode 1)
// frees the lowest active slot whose age (now minus stamp, modulo 2^32) has
// reached timeout_ms. A word is held in an input register until the output
// register can take its result; all slots are compared and aged in parallel
// and the table is updated as the result enters the output register, so each
// result passes through the input and then the output register before it
// shows on m_valid; one word is taken every cycle while m_ready is high. The
// user must write timeout_ms through cfg_wr_en / cfg_wr_data only while the
// block is idle; the block itself does not enforce this. It resets to 60000.
module keyed_slot_table_with_timeout_unit #(
    parameter int SLOTS      = 4,
    parameter int NAME_BYTES = 15
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [kst_pkg::TIME_W-1:0]     cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_opcode,
    input  logic [kst_pkg::NAME_LOW_W-1:0] s_name_low,
    input  logic [kst_pkg::NAME_HIGH_W-1:0] s_name_high,
    input  logic [kst_pkg::TIME_W-1:0]     s_now_ms,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [kst_pkg::OUT_IDX_W-1:0]  m_slot_index,
    output logic [kst_pkg::STATUS_W-1:0]   m_status
);

    import kst_pkg::*;

    localparam int NAME_W = 8 * NAME_BYTES;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [TIME_W-1:0] timeout_reg;

    logic              in_valid_reg;
    op_t               in_op_reg;
    logic [NAME_W-1:0] in_name_reg;
    logic [TIME_W-1:0] in_now_reg;

    logic [NAME_W-1:0] slot_name_reg  [SLOTS];
    logic [TIME_W-1:0] slot_stamp_reg [SLOTS];
    logic [SLOTS-1:0]  slot_active_reg;
    logic [SLOTS-1:0]  slot_active_next;

    logic                 out_valid_reg;
    logic [OUT_IDX_W-1:0] out_idx_reg;
    status_t              out_status_reg;
    logic [OUT_IDX_W-1:0] out_idx_next;
    status_t              out_status_next;

    logic [NAME_MAX_W-1:0] name_full;
    logic                  take;
    logic                  advance;

    logic [SLOTS-1:0]  hit_vec;
    logic [SLOTS-1:0]  free_vec;
    logic [SLOTS-1:0]  aged_vec;
    logic              hit_found;
    logic              free_found;
    logic              aged_found;
    logic [SLOT_W-1:0] hit_idx;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] aged_idx;
    logic [TIME_W-1:0] age;

    logic              wr_stamp;
    logic              wr_name;
    logic [SLOT_W-1:0] wr_idx;

    assign name_full = {s_name_high, s_name_low};
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign take      = s_valid && s_ready;

    assign m_valid      = out_valid_reg;
    assign m_slot_index = out_idx_reg;
    assign m_status     = out_status_reg;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            age         = in_now_reg - slot_stamp_reg[i];
            hit_vec[i]  = slot_active_reg[i] && (slot_name_reg[i] == in_name_reg);
            free_vec[i] = !slot_active_reg[i];
            aged_vec[i] = slot_active_reg[i] && (age >= timeout_reg);
        end
    end

    kst_prio #(.N(SLOTS), .IDX_W(SLOT_W)) u_hit_prio (
        .req   (hit_vec),
        .found (hit_found),
        .idx   (hit_idx)
    );

    kst_prio #(.N(SLOTS), .IDX_W(SLOT_W)) u_free_prio (
        .req   (free_vec),
        .found (free_found),
        .idx   (free_idx)
    );

    kst_prio #(.N(SLOTS), .IDX_W(SLOT_W)) u_aged_prio (
        .req   (aged_vec),
        .found (aged_found),
        .idx   (aged_idx)
    );

    always_comb begin
        wr_stamp         = 1'b0;
        wr_name          = 1'b0;
        wr_idx           = free_idx;
        slot_active_next = slot_active_reg;
        out_idx_next     = '0;
        out_status_next  = ST_NONE;
        unique case (in_op_reg)
            OP_UPDATE: begin
                if (hit_found) begin
                    wr_stamp        = advance;
                    wr_idx          = hit_idx;
                    out_idx_next    = OUT_IDX_W'(hit_idx);
                    out_status_next = ST_MATCHED;
                end else if (free_found) begin
                    wr_stamp        = advance;
                    wr_name         = advance;
                    wr_idx          = free_idx;
                    out_idx_next    = OUT_IDX_W'(free_idx);
                    out_status_next = ST_CLAIMED;
                    if (advance) begin
                        slot_active_next[free_idx] = 1'b1;
                    end
                end else begin
                    out_status_next = ST_FULL;
                end
            end
            OP_TIMEOUT: begin
                if (aged_found) begin
                    out_idx_next    = OUT_IDX_W'(aged_idx);
                    out_status_next = ST_EXPIRED;
                    if (advance) begin
                        slot_active_next[aged_idx] = 1'b0;
                    end
                end
            end
            default: begin
                out_status_next = ST_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg     <= TIMEOUT_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            slot_active_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            if (take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            slot_active_reg <= slot_active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_op_reg   <= op_t'(s_opcode);
            in_name_reg <= name_full[NAME_W-1:0];
            in_now_reg  <= s_now_ms;
        end
        if (advance) begin
            out_idx_reg    <= out_idx_next;
            out_status_reg <= out_status_next;
        end
        if (wr_stamp) begin
            slot_stamp_reg[wr_idx] <= in_now_reg;
        end
        if (wr_name) begin
            slot_name_reg[wr_idx] <= in_name_reg;
        end
    end

endmodule

// File: hdl/kst_checker.sv
// Port-level checks for the keyed slot table with timeout, bound to the top.
// Depends on kst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kst_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [kst_pkg::OUT_IDX_W-1:0] m_slot_index,
    input logic [kst_pkg::STATUS_W-1:0]  m_status
);

    import kst_pkg::*;

    `KST_ASSERT_NEXT_ALWAYS(a_reset_clears_out, aclk, !aresetn, !m_valid, "result valid after reset")

    `KST_ASSERT_NOW(a_status_legal, aclk, aresetn, m_valid, m_status <= ST_NONE, "status code out of range")

    `KST_ASSERT_NOW(a_idle_index_zero, aclk, aresetn, m_valid && (m_status == ST_FULL || m_status == ST_NONE), m_slot_index == '0, "full or no expiry with nonzero slot")

    `KST_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_slot_index) && $stable(m_status), "stalled result word changed")

endmodule

bind keyed_slot_table_with_timeout_unit kst_checker u_kst_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_slot_index (m_slot_index),
    .m_status     (m_status)
);
